// File: design/mmx_pkg.sv
// Shared constants, types and request structs for the 16x8 Q1.31 matrix mixer.
// No dependencies; used by mmx_mac and the top level of the mixer.
`timescale 1ns / 1ps

package mmx_pkg;

	localparam int NUM_SOURCES = 16;
	localparam int NUM_SINKS   = 8;

	localparam int SRC_W      = 4;   // source index
	localparam int SINK_W     = 3;   // sink index
	localparam int SRC_CNT_W  = 5;   // active_sources register
	localparam int SINK_CNT_W = 4;   // active_sinks register
	localparam int SAMPLE_W   = 32;
	localparam int ACC_W      = 36;
	localparam int PROD_W     = 2 * SAMPLE_W;
	localparam int GAIN_SHIFT = 31;
	localparam int GAIN_AW    = SRC_W + SINK_W;
	localparam int GAIN_DEPTH = NUM_SOURCES * NUM_SINKS;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic signed [SAMPLE_W-1:0] GAIN_UNITY = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0]    ACC_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0]    ACC_MIN    = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_GAIN   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_SOURCES = 1'b0,
		REG_ACTIVE_SINKS   = 1'b1
	} cfg_reg_t;

	// one multiply-accumulate request, issued together with the RAM reads
	typedef struct packed {
		logic              vld;
		logic [SINK_W-1:0] sink;
		logic              acc_ok;   // accumulator entry written since last frame end
		logic              gain_ok;  // gain cell written since reset
		logic              ident;    // diagonal cell of the reset matrix
	} mac_req_t;

	// accumulator write-back
	typedef struct packed {
		logic                    we;
		logic [SINK_W-1:0]       addr;
		logic signed [ACC_W-1:0] data;
	} acc_wr_t;

endpackage

// File: design/mmx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instanced for the gain table and the sink accumulators.
`timescale 1ns / 1ps

module mmx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/mmx_mac.sv
// Two-stage multiply-accumulate datapath: Q1.31 multiply, floor shift, 36-bit
// saturating add and accumulator write-back. Depends on mmx_pkg.
`timescale 1ns / 1ps

module mmx_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mmx_pkg::mac_req_t                     req,
	input  logic signed [mmx_pkg::SAMPLE_W-1:0]   sample,
	input  logic signed [mmx_pkg::SAMPLE_W-1:0]   gain_rdata,
	input  logic signed [mmx_pkg::ACC_W-1:0]      acc_rdata,
	output mmx_pkg::acc_wr_t                      acc_wr,
	output logic                                  busy
);

	mmx_pkg::mac_req_t                    req_s1;
	logic signed [mmx_pkg::SAMPLE_W-1:0]  gain_s1;
	logic signed [mmx_pkg::ACC_W-1:0]     acc_s1;

	logic                                 vld_s2;
	logic [mmx_pkg::SINK_W-1:0]           sink_s2;
	logic signed [mmx_pkg::PROD_W-1:0]    prod_s2;
	logic signed [mmx_pkg::ACC_W-1:0]     acc_s2;

	logic signed [mmx_pkg::ACC_W:0]       sum;
	logic signed [mmx_pkg::ACC_W-1:0]     sum_sat;

	// unwritten entries read as their reset value
	always_comb begin
		if (req_s1.gain_ok) begin
			gain_s1 = gain_rdata;
		end else if (req_s1.ident) begin
			gain_s1 = mmx_pkg::GAIN_UNITY;
		end else begin
			gain_s1 = '0;
		end
		acc_s1 = req_s1.acc_ok ? acc_rdata : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
			vld_s2 <= 1'b0;
		end else begin
			req_s1 <= req;
			vld_s2 <= req_s1.vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= gain_s1 * sample;
		acc_s2  <= acc_s1;
		sink_s2 <= req_s1.sink;
	end

	// product >> 31 is bits [63:31], sign-extended to the accumulator width
	always_comb begin
		sum = {acc_s2[mmx_pkg::ACC_W-1], acc_s2}
			+ {{(mmx_pkg::ACC_W + 1 - (mmx_pkg::PROD_W - mmx_pkg::GAIN_SHIFT)){
				prod_s2[mmx_pkg::PROD_W-1]}},
			   prod_s2[mmx_pkg::PROD_W-1:mmx_pkg::GAIN_SHIFT]};
		if (sum[mmx_pkg::ACC_W] != sum[mmx_pkg::ACC_W-1]) begin
			sum_sat = sum[mmx_pkg::ACC_W] ? mmx_pkg::ACC_MIN : mmx_pkg::ACC_MAX;
		end else begin
			sum_sat = sum[mmx_pkg::ACC_W-1:0];
		end
	end

	assign acc_wr.we   = vld_s2;
	assign acc_wr.addr = sink_s2;
	assign acc_wr.data = sum_sat;
	assign busy        = req_s1.vld | vld_s2;

endmodule

// File: design/matrix_mixer_16x8_q31.sv
// Top level of the 16-source, 8-sink Q1.31 matrix mixer: request sequencer,
// gain and accumulator RAMs. Depends on mmx_pkg, mmx_ram and mmx_mac.
`timescale 1ns / 1ps

// A gain request (mode 1) writes its gain cell directly. A sample request (mode 0) steps
// through the active sinks, one gain and accumulator read a cycle, and holds
// in_stall high until the two-stage multiply-accumulate has written back. A sample
// from the last active source then reads out each active sink, a read state and
// a data state per sink (waiting while out_stall is high), and clears the
// accumulators. Gain cells that were never written read as the identity matrix,
// so no clearing pass follows reset.
module matrix_mixer_16x8_q31 (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [mmx_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mmx_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  mode,
	input  logic [mmx_pkg::SRC_W-1:0]             source_index,
	input  logic [mmx_pkg::SINK_W-1:0]            sink_index,
	input  logic signed [mmx_pkg::SAMPLE_W-1:0]   value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [mmx_pkg::SINK_W-1:0]            out_sink,
	output logic signed [mmx_pkg::SAMPLE_W-1:0]   out_sample,
	output logic                                  last_sink
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT_RD,
		ST_EMIT_WAIT
	} state_t;

	state_t                                state_q;
	logic [mmx_pkg::SRC_CNT_W-1:0]         act_src_q;
	logic [mmx_pkg::SINK_CNT_W-1:0]        act_snk_q;
	logic [mmx_pkg::SRC_W-1:0]             src_q;
	logic [mmx_pkg::SINK_W-1:0]            j_q;
	logic                                  last_q;
	logic signed [mmx_pkg::SAMPLE_W-1:0]   sample_q;
	logic                                  out_valid_q;
	logic [mmx_pkg::GAIN_DEPTH-1:0]        gain_vld_q;
	logic [mmx_pkg::NUM_SINKS-1:0]         acc_vld_q;

	logic [mmx_pkg::SRC_CNT_W-1:0]         ns_eff;
	logic [mmx_pkg::SINK_CNT_W-1:0]        nk_eff;
	logic [mmx_pkg::SINK_W-1:0]            nk_m1;
	logic [mmx_pkg::SINK_CNT_W-1:0]        nk_dec;
	logic [mmx_pkg::SRC_CNT_W-1:0]         ns_m1;
	logic                                  accept;
	logic                                  gain_we;
	logic [mmx_pkg::GAIN_AW-1:0]           gain_raddr;
	logic signed [mmx_pkg::SAMPLE_W-1:0]   gain_rdata;
	logic signed [mmx_pkg::ACC_W-1:0]      acc_rdata;
	logic signed [mmx_pkg::ACC_W-1:0]      acc_emit;
	logic signed [mmx_pkg::SAMPLE_W-1:0]   acc_sat;
	logic                                  acc_clr;
	logic                                  mac_busy;
	mmx_pkg::mac_req_t                     mac_req;
	mmx_pkg::acc_wr_t                      acc_wr;

	// registers used clamped to their legal ranges
	always_comb begin
		if (act_src_q == '0) begin
			ns_eff = mmx_pkg::SRC_CNT_W'(1);
		end else if (act_src_q > mmx_pkg::SRC_CNT_W'(mmx_pkg::NUM_SOURCES)) begin
			ns_eff = mmx_pkg::SRC_CNT_W'(mmx_pkg::NUM_SOURCES);
		end else begin
			ns_eff = act_src_q;
		end
		if (act_snk_q == '0) begin
			nk_eff = mmx_pkg::SINK_CNT_W'(1);
		end else if (act_snk_q > mmx_pkg::SINK_CNT_W'(mmx_pkg::NUM_SINKS)) begin
			nk_eff = mmx_pkg::SINK_CNT_W'(mmx_pkg::NUM_SINKS);
		end else begin
			nk_eff = act_snk_q;
		end
		nk_dec = nk_eff - 1'b1;
		nk_m1  = nk_dec[mmx_pkg::SINK_W-1:0];
		ns_m1  = ns_eff - 1'b1;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign gain_we  = accept && (mode == mmx_pkg::MODE_GAIN);

	assign gain_raddr = {src_q, j_q};

	assign mac_req.vld     = (state_q == ST_MAC);
	assign mac_req.sink    = j_q;
	assign mac_req.acc_ok  = acc_vld_q[j_q];
	assign mac_req.gain_ok = gain_vld_q[gain_raddr];
	assign mac_req.ident   = (mmx_pkg::SRC_W'(j_q) == src_q);

	mmx_ram #(
		.WIDTH (mmx_pkg::SAMPLE_W),
		.DEPTH (mmx_pkg::GAIN_DEPTH)
	) u_gain_ram (
		.clk   (clk),
		.we    (gain_we),
		.waddr ({source_index, sink_index}),
		.wdata (value),
		.raddr (gain_raddr),
		.rdata (gain_rdata)
	);

	mmx_ram #(
		.WIDTH (mmx_pkg::ACC_W),
		.DEPTH (mmx_pkg::NUM_SINKS)
	) u_acc_ram (
		.clk   (clk),
		.we    (acc_wr.we),
		.waddr (acc_wr.addr),
		.wdata (acc_wr.data),
		.raddr (j_q),
		.rdata (acc_rdata)
	);

	mmx_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (mac_req),
		.sample     (sample_q),
		.gain_rdata (gain_rdata),
		.acc_rdata  (acc_rdata),
		.acc_wr     (acc_wr),
		.busy       (mac_busy)
	);

	// read-out: j_q is unchanged between the read and the data cycle
	always_comb begin
		acc_emit = acc_vld_q[j_q] ? acc_rdata : '0;
		if (acc_emit[mmx_pkg::ACC_W-1:mmx_pkg::SAMPLE_W-1] == '0 ||
			acc_emit[mmx_pkg::ACC_W-1:mmx_pkg::SAMPLE_W-1] == '1) begin
			acc_sat = acc_emit[mmx_pkg::SAMPLE_W-1:0];
		end else if (acc_emit[mmx_pkg::ACC_W-1]) begin
			acc_sat = {1'b1, {(mmx_pkg::SAMPLE_W-1){1'b0}}};
		end else begin
			acc_sat = {1'b0, {(mmx_pkg::SAMPLE_W-1){1'b1}}};
		end
	end

	assign acc_clr = (state_q == ST_EMIT_WAIT) && (j_q == nk_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_vld_q <= '0;
			acc_vld_q  <= '0;
		end else begin
			if (gain_we) begin
				gain_vld_q[{source_index, sink_index}] <= 1'b1;
			end
			if (acc_clr) begin
				acc_vld_q <= '0;
			end else if (acc_wr.we) begin
				acc_vld_q[acc_wr.addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_src_q <= mmx_pkg::SRC_CNT_W'(mmx_pkg::NUM_SOURCES);
			act_snk_q <= mmx_pkg::SINK_CNT_W'(mmx_pkg::NUM_SINKS);
		end else if (cfg_wr_en) begin
			unique case (mmx_pkg::cfg_reg_t'(cfg_index))
				mmx_pkg::REG_ACTIVE_SOURCES: begin
					act_src_q <= cfg_data;
				end
				mmx_pkg::REG_ACTIVE_SINKS: begin
					act_snk_q <= cfg_data[mmx_pkg::SINK_CNT_W-1:0];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			src_q       <= '0;
			j_q         <= '0;
			last_q      <= 1'b0;
			sample_q    <= '0;
			out_valid_q <= 1'b0;
			out_sink    <= '0;
			out_sample  <= '0;
			last_sink   <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && mode == mmx_pkg::MODE_SAMPLE &&
						mmx_pkg::SRC_CNT_W'(source_index) < ns_eff) begin
						src_q    <= source_index;
						sample_q <= value;
						last_q   <= (mmx_pkg::SRC_CNT_W'(source_index) == ns_m1);
						j_q      <= '0;
						state_q  <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (j_q == nk_m1) begin
						state_q <= ST_DRAIN;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!mac_busy) begin
						j_q     <= '0;
						state_q <= last_q ? ST_EMIT_RD : ST_IDLE;
					end
				end
				ST_EMIT_RD: begin
					// output register is empty or being taken
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_EMIT_WAIT;
					end
				end
				ST_EMIT_WAIT: begin
					out_valid_q <= 1'b1;
					out_sink    <= j_q;
					out_sample  <= acc_sat;
					last_sink   <= (j_q == nk_m1);
					if (j_q == nk_m1) begin
						state_q <= ST_IDLE;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_EMIT_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// accumulator write-back only from a running sample request
	a_acc_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc_wr.we |-> (state_q == ST_MAC || state_q == ST_DRAIN))
		else $error("accumulator write outside sample processing");

	a_acc_wr_active: assert property (@(posedge clk) disable iff (!arst_n)
		acc_wr.we |-> (acc_wr.addr <= nk_m1))
		else $error("accumulator write to inactive sink");

	// read-out never overlaps pending write-back
	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_RD || state_q == ST_EMIT_WAIT) |-> !mac_busy)
		else $error("read-out while multiply-accumulate busy");

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_EMIT_WAIT)
		else $error("result loaded outside read-out");

endmodule
